// ===== sv/obbcp_pkg.sv =====
package obbcp_pkg;

    localparam int AXIS_FRAC_BITS_DEF = 14;
    // working width of the world-frame corner sums before rounding
    localparam int WS_W = 50;
    localparam logic [30:0] PEN_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] rel_pos_x;
        logic signed [31:0] rel_pos_y;
        logic [30:0]        self_half_w;
        logic [30:0]        self_half_h;
        logic signed [15:0] self_axis_cos;
        logic signed [15:0] self_axis_sin;
        logic [30:0]        other_half_w;
        logic [30:0]        other_half_h;
        logic signed [15:0] other_axis_cos;
        logic signed [15:0] other_axis_sin;
        logic [30:0]        pen_in;
    } t_in;

    typedef struct packed {
        logic               has_contact;
        logic               improved;
        logic signed [31:0] contact_x;
        logic signed [31:0] contact_y;
        logic [30:0]        pen_out;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
    } t_out;

    // self-box values that travel alongside the corner math
    typedef struct packed {
        logic [30:0]        hw;
        logic [30:0]        hh;
        logic signed [15:0] c;
        logic signed [15:0] s;
        logic [30:0]        pen;
    } t_side;

    typedef struct packed {
        logic       vld;
        logic       contact;
        logic [2:0] cnt;
    } t_ctl;

endpackage

// ===== sv/oriented_box_corner_penetration.sv =====
// Oriented box corner penetration test, fully pipelined.
// Input channel: i_valid / o_stall with one box pair per transaction in i_data.
// Output channel: o_valid / i_stall with one contact result per transaction.
// A transaction moves on a rising edge where valid is high and stall is low.
// A new pair is accepted every cycle while o_stall is low; throughput is
// one pair per clock, set by the ten-stage pipeline (corner transform,
// reduction, contact divide).
// The divide by a count of three inside corners is split into two reciprocal
// digit steps so no single stage holds a long carry chain.
// When the receiver stalls a valid result, the whole pipeline freezes and
// o_stall rises in the same cycle; nothing is dropped or repeated.
// Synchronous active-low reset clears all valid bits; payload registers
// are not reset. The block has no state between pairs.
module oriented_box_corner_penetration #(
    parameter int AXIS_FRAC_BITS = obbcp_pkg::AXIS_FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  obbcp_pkg::t_in  i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output obbcp_pkg::t_out o_data
);
    import obbcp_pkg::*;

    localparam int W_PX = WS_W + 17 - 2 * AXIS_FRAC_BITS;
    localparam int W_CP = W_PX + 18;

    logic en;
    logic c_vld;
    logic signed [W_PX-1:0] c_px [4], c_py [4];
    t_side c_side, r_side;
    t_ctl  r_ctl;
    logic [30:0] r_cand [4];
    logic signed [W_CP-1:0] r_sxc, r_sys, r_sxs, r_syc;

    // hold every stage while a finished result waits
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    obbcp_corner #(.AXIS_FRAC_BITS(AXIS_FRAC_BITS)) u_corner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_in    (i_data),
        .o_vld   (c_vld),
        .o_px    (c_px),
        .o_py    (c_py),
        .o_side  (c_side)
    );

    obbcp_reduce #(.AXIS_FRAC_BITS(AXIS_FRAC_BITS)) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (c_vld),
        .i_px    (c_px),
        .i_py    (c_py),
        .i_side  (c_side),
        .o_ctl   (r_ctl),
        .o_cand  (r_cand),
        .o_sxc   (r_sxc),
        .o_sys   (r_sys),
        .o_sxs   (r_sxs),
        .o_syc   (r_syc),
        .o_side  (r_side)
    );

    obbcp_resolve #(.AXIS_FRAC_BITS(AXIS_FRAC_BITS)) u_resolve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (r_ctl),
        .i_cand  (r_cand),
        .i_sxc   (r_sxc),
        .i_sys   (r_sys),
        .i_sxs   (r_sxs),
        .i_syc   (r_syc),
        .i_side  (r_side),
        .o_vld   (o_valid),
        .o_out   (o_data)
    );

endmodule

// ===== sv/obbcp_corner.sv =====
module obbcp_corner #(
    parameter int AXIS_FRAC_BITS = obbcp_pkg::AXIS_FRAC_BITS_DEF,
    localparam int W_PX = obbcp_pkg::WS_W + 17 - 2 * AXIS_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  obbcp_pkg::t_in        i_in,
    output logic                  o_vld,
    output logic signed [W_PX-1:0] o_px [4],
    output logic signed [W_PX-1:0] o_py [4],
    output obbcp_pkg::t_side      o_side
);
    import obbcp_pkg::*;

    localparam int A    = AXIS_FRAC_BITS;
    localparam int W_W  = WS_W - A;
    localparam int W_M  = W_W + 16;
    localparam int W_PS = W_W + 17;
    localparam logic signed [WS_W-1:0] HALF_WS = WS_W'(1) <<< (A - 1);
    localparam logic signed [W_PS-1:0] HALF_PS = W_PS'(1) <<< (A - 1);

    logic r1_vld, r2_vld, r3_vld, r4_vld;
    t_side r1_side, r2_side, r3_side, r4_side, n1_side;

    logic signed [31:0] r1_rx, r1_ry;
    logic signed [47:0] r1_pwc, r1_phs, r1_pws, r1_phc;
    logic signed [47:0] n1_pwc, n1_phs, n1_pws, n1_phc;

    logic signed [W_W-1:0] r2_wx [4], r2_wy [4], n2_wx [4], n2_wy [4];
    logic signed [W_M-1:0] r3_xc [4], r3_ys [4], r3_yc [4], r3_xs [4];
    logic signed [W_M-1:0] n3_xc [4], n3_ys [4], n3_yc [4], n3_xs [4];
    logic signed [W_PX-1:0] r4_px [4], r4_py [4], n4_px [4], n4_py [4];

    // stage 1: other-box half extents times its axis
    always_comb begin
        n1_pwc = $signed({1'b0, i_in.other_half_w}) * i_in.other_axis_cos;
        n1_phs = $signed({1'b0, i_in.other_half_h}) * i_in.other_axis_sin;
        n1_pws = $signed({1'b0, i_in.other_half_w}) * i_in.other_axis_sin;
        n1_phc = $signed({1'b0, i_in.other_half_h}) * i_in.other_axis_cos;
        n1_side.hw  = i_in.self_half_w;
        n1_side.hh  = i_in.self_half_h;
        n1_side.c   = i_in.self_axis_cos;
        n1_side.s   = i_in.self_axis_sin;
        n1_side.pen = i_in.pen_in;
    end

    // stage 2: corners in world axes, rounded
    always_comb begin
        logic signed [WS_W-1:0] base_x, base_y, ta, tb, tc, td, sum_x, sum_y;
        base_x = (WS_W'(r1_rx) <<< A) + HALF_WS;
        base_y = (WS_W'(r1_ry) <<< A) + HALF_WS;
        for (int k = 0; k < 4; k++) begin
            ta = ((k & 2) != 0) ? WS_W'(r1_pwc) : -WS_W'(r1_pwc);
            tb = ((k & 1) != 0) ? WS_W'(r1_phs) : -WS_W'(r1_phs);
            tc = ((k & 2) != 0) ? WS_W'(r1_pws) : -WS_W'(r1_pws);
            td = ((k & 1) != 0) ? WS_W'(r1_phc) : -WS_W'(r1_phc);
            sum_x = base_x + ta - tb;
            sum_y = base_y + tc + td;
            n2_wx[k] = sum_x[WS_W-1:A];
            n2_wy[k] = sum_y[WS_W-1:A];
        end
    end

    // stage 3: projection products onto self axes
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n3_xc[k] = W_M'(r2_wx[k]) * W_M'(r2_side.c);
            n3_ys[k] = W_M'(r2_wy[k]) * W_M'(r2_side.s);
            n3_yc[k] = W_M'(r2_wy[k]) * W_M'(r2_side.c);
            n3_xs[k] = W_M'(r2_wx[k]) * W_M'(r2_side.s);
        end
    end

    // stage 4: sum and round into the self frame
    always_comb begin
        logic signed [W_PS-1:0] sx, sy;
        for (int k = 0; k < 4; k++) begin
            sx = W_PS'(r3_xc[k]) + W_PS'(r3_ys[k]) + HALF_PS;
            sy = W_PS'(r3_yc[k]) - W_PS'(r3_xs[k]) + HALF_PS;
            n4_px[k] = sx[W_PS-1:A];
            n4_py[k] = sy[W_PS-1:A];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_rx   <= i_in.rel_pos_x;
            r1_ry   <= i_in.rel_pos_y;
            r1_pwc  <= n1_pwc;
            r1_phs  <= n1_phs;
            r1_pws  <= n1_pws;
            r1_phc  <= n1_phc;
            r1_side <= n1_side;
            r2_wx   <= n2_wx;
            r2_wy   <= n2_wy;
            r2_side <= r1_side;
            r3_xc   <= n3_xc;
            r3_ys   <= n3_ys;
            r3_yc   <= n3_yc;
            r3_xs   <= n3_xs;
            r3_side <= r2_side;
            r4_px   <= n4_px;
            r4_py   <= n4_py;
            r4_side <= r3_side;
        end
    end

    assign o_vld  = r4_vld;
    assign o_px   = r4_px;
    assign o_py   = r4_py;
    assign o_side = r4_side;

endmodule

// ===== sv/obbcp_reduce.sv =====
module obbcp_reduce #(
    parameter int AXIS_FRAC_BITS = obbcp_pkg::AXIS_FRAC_BITS_DEF,
    localparam int W_PX  = obbcp_pkg::WS_W + 17 - 2 * AXIS_FRAC_BITS,
    localparam int W_SUM = W_PX + 2,
    localparam int W_CP  = W_SUM + 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic signed [W_PX-1:0] i_px [4],
    input  logic signed [W_PX-1:0] i_py [4],
    input  obbcp_pkg::t_side       i_side,
    output obbcp_pkg::t_ctl        o_ctl,
    output logic [30:0]            o_cand [4],
    output logic signed [W_CP-1:0] o_sxc,
    output logic signed [W_CP-1:0] o_sys,
    output logic signed [W_CP-1:0] o_sxs,
    output logic signed [W_CP-1:0] o_syc,
    output obbcp_pkg::t_side       o_side
);
    import obbcp_pkg::*;

    localparam int W_C = W_PX + 1;
    localparam logic signed [W_C-1:0] PEN_MAX_C = W_C'(PEN_MAX);

    function automatic logic [30:0] sat_pen(input logic signed [W_C-1:0] v);
        // zero marks a candidate that is not positive
        if (v <= 0)
            return '0;
        else if (v > PEN_MAX_C)
            return PEN_MAX;
        else
            return v[30:0];
    endfunction

    logic r5_vld;
    t_side r5_side, r6_side;
    t_ctl r6_ctl;
    logic signed [W_PX-1:0] r5_minx, r5_maxx, r5_miny, r5_maxy;
    logic signed [W_PX-1:0] n5_minx, n5_maxx, n5_miny, n5_maxy;
    logic [2:0] r5_cnt, n5_cnt;
    logic signed [W_SUM-1:0] r5_sumx, r5_sumy, n5_sumx, n5_sumy;

    logic [30:0] r6_cand [4], n6_cand [4];
    logic signed [W_CP-1:0] r6_sxc, r6_sys, r6_sxs, r6_syc;
    logic n6_contact;

    // stage 5: bounds of the projected corners and the inside sums
    always_comb begin
        logic signed [W_PX-1:0] hw_e, hh_e;
        hw_e = W_PX'($signed({1'b0, i_side.hw}));
        hh_e = W_PX'($signed({1'b0, i_side.hh}));
        n5_minx = i_px[0];
        n5_maxx = i_px[0];
        n5_miny = i_py[0];
        n5_maxy = i_py[0];
        n5_cnt  = '0;
        n5_sumx = '0;
        n5_sumy = '0;
        for (int k = 0; k < 4; k++) begin
            if (i_px[k] < n5_minx) n5_minx = i_px[k];
            if (i_px[k] > n5_maxx) n5_maxx = i_px[k];
            if (i_py[k] < n5_miny) n5_miny = i_py[k];
            if (i_py[k] > n5_maxy) n5_maxy = i_py[k];
            if (i_px[k] >= -hw_e && i_px[k] <= hw_e &&
                i_py[k] >= -hh_e && i_py[k] <= hh_e) begin
                n5_cnt  = n5_cnt + 3'd1;
                n5_sumx = n5_sumx + W_SUM'(i_px[k]);
                n5_sumy = n5_sumy + W_SUM'(i_py[k]);
            end
        end
    end

    // stage 6: separation test, face penetrations, contact rotation products
    always_comb begin
        logic signed [W_PX-1:0] hw_e, hh_e;
        hw_e = W_PX'($signed({1'b0, r5_side.hw}));
        hh_e = W_PX'($signed({1'b0, r5_side.hh}));
        n6_contact = !(r5_maxx <= -hw_e || r5_minx >= hw_e ||
                       r5_maxy <= -hh_e || r5_miny >= hh_e) && (r5_cnt != 3'd0);
        n6_cand[0] = sat_pen(W_C'(hw_e) - W_C'(r5_minx));
        n6_cand[1] = sat_pen(W_C'(r5_maxx) + W_C'(hw_e));
        n6_cand[2] = sat_pen(W_C'(hh_e) - W_C'(r5_miny));
        n6_cand[3] = sat_pen(W_C'(r5_maxy) + W_C'(hh_e));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld     <= 1'b0;
            r6_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r5_vld     <= i_vld;
            r6_ctl.vld <= r5_vld;
            r5_minx <= n5_minx;
            r5_maxx <= n5_maxx;
            r5_miny <= n5_miny;
            r5_maxy <= n5_maxy;
            r5_cnt  <= n5_cnt;
            r5_sumx <= n5_sumx;
            r5_sumy <= n5_sumy;
            r5_side <= i_side;
            r6_ctl.contact <= n6_contact;
            r6_ctl.cnt     <= r5_cnt;
            r6_cand <= n6_cand;
            r6_sxc  <= W_CP'(r5_sumx) * W_CP'(r5_side.c);
            r6_sys  <= W_CP'(r5_sumy) * W_CP'(r5_side.s);
            r6_sxs  <= W_CP'(r5_sumx) * W_CP'(r5_side.s);
            r6_syc  <= W_CP'(r5_sumy) * W_CP'(r5_side.c);
            r6_side <= r5_side;
        end
    end

    assign o_ctl  = r6_ctl;
    assign o_cand = r6_cand;
    assign o_sxc  = r6_sxc;
    assign o_sys  = r6_sys;
    assign o_sxs  = r6_sxs;
    assign o_syc  = r6_syc;
    assign o_side = r6_side;

endmodule

// ===== sv/obbcp_resolve.sv =====
module obbcp_resolve #(
    parameter int AXIS_FRAC_BITS = obbcp_pkg::AXIS_FRAC_BITS_DEF,
    localparam int W_PX  = obbcp_pkg::WS_W + 17 - 2 * AXIS_FRAC_BITS,
    localparam int W_CP  = W_PX + 18
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  obbcp_pkg::t_ctl        i_ctl,
    input  logic [30:0]            i_cand [4],
    input  logic signed [W_CP-1:0] i_sxc,
    input  logic signed [W_CP-1:0] i_sys,
    input  logic signed [W_CP-1:0] i_sxs,
    input  logic signed [W_CP-1:0] i_syc,
    input  obbcp_pkg::t_side       i_side,
    output logic                   o_vld,
    output obbcp_pkg::t_out        o_out
);
    import obbcp_pkg::*;

    localparam int A   = AXIS_FRAC_BITS;
    localparam int W_N = W_CP + 2;
    localparam int W_Q = W_N - A;
    // x = q + 3 * 2^32 is nonnegative for any clamped q
    localparam logic [34:0] DIV3_BIAS = 35'h3_0000_0000;
    localparam logic [17:0] RECIP_HI  = 18'd174763;
    localparam logic [19:0] RECIP_LO  = 20'd699051;

    // clamp to 34 bits: beyond that every divisor saturates the result anyway
    function automatic logic signed [33:0] clamp34(input logic signed [W_Q-1:0] v);
        if ((&v[W_Q-1:33]) || !(|v[W_Q-1:33]))
            return v[33:0];
        else if (v[W_Q-1])
            return 34'h2_0000_0000;
        else
            return 34'h1_FFFF_FFFF;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if ((&v[35:31]) || !(|v[35:31]))
            return v[31:0];
        else if (v[35])
            return 32'h8000_0000;
        else
            return 32'h7FFF_FFFF;
    endfunction

    t_ctl r7_ctl, r8_ctl, r9_ctl;
    logic r10_vld;
    t_out r10_out, n10_out;

    logic signed [33:0] r7_qx, r7_qy, r8_qx, r8_qy, r9_qx, r9_qy;
    logic signed [33:0] n7_qx, n7_qy;
    logic [30:0] r7_pen, r8_pen, r9_pen, n7_pen;
    logic signed [15:0] r7_nx, r7_ny, r8_nx, r8_ny, r9_nx, r9_ny, n7_nx, n7_ny;
    logic r7_imp, r8_imp, r9_imp, n7_imp;

    logic [15:0] r8_qhx, r8_qhy, r9_qhx, r9_qhy;
    logic [16:0] r8_xhx, r8_xhy;
    logic [17:0] r8_xlx, r8_xly;
    logic [18:0] r9_qlx, r9_qly;

    logic [34:0] bx, by, prod_hx, prod_hy;
    logic [39:0] prod_lx, prod_ly;
    logic [1:0]  rhx, rhy;

    // stage 7: rounded quotient by the axis unit; pick the best face
    always_comb begin
        logic signed [W_N-1:0] rnd, sum_x, sum_y;
        logic signed [15:0] cn [4][2];
        rnd   = W_N'(i_ctl.cnt) << (A - 1);
        sum_x = W_N'(i_sxc) - W_N'(i_sys) + rnd;
        sum_y = W_N'(i_sxs) + W_N'(i_syc) + rnd;
        n7_qx = clamp34(sum_x[W_N-1:A]);
        n7_qy = clamp34(sum_y[W_N-1:A]);
        cn[0][0] = i_side.c;
        cn[0][1] = i_side.s;
        cn[1][0] = -i_side.c;
        cn[1][1] = -i_side.s;
        cn[2][0] = -i_side.s;
        cn[2][1] = i_side.c;
        cn[3][0] = i_side.s;
        cn[3][1] = -i_side.c;
        n7_pen = i_side.pen;
        n7_nx  = '0;
        n7_ny  = '0;
        n7_imp = 1'b0;
        if (i_ctl.contact) begin
            for (int k = 0; k < 4; k++) begin
                if (i_cand[k] != '0 && (i_cand[k] < n7_pen || n7_pen == '0)) begin
                    n7_pen = i_cand[k];
                    n7_nx  = cn[k][0];
                    n7_ny  = cn[k][1];
                    n7_imp = 1'b1;
                end
            end
        end
    end

    // stage 8: high digit of the divide by three
    always_comb begin
        bx = {r7_qx[33], r7_qx} + DIV3_BIAS;
        by = {r7_qy[33], r7_qy} + DIV3_BIAS;
        prod_hx = 35'(bx[34:18]) * 35'(RECIP_HI);
        prod_hy = 35'(by[34:18]) * 35'(RECIP_HI);
    end

    // stage 9: low digit with the remainder carried down
    always_comb begin
        rhx = 2'(r8_xhx - 17'(r8_qhx) * 17'd3);
        rhy = 2'(r8_xhy - 17'(r8_qhy) * 17'd3);
        prod_lx = 40'({rhx, r8_xlx}) * 40'(RECIP_LO);
        prod_ly = 40'({rhy, r8_xly}) * 40'(RECIP_LO);
    end

    // stage 10: select by corner count, saturate
    always_comb begin
        logic [34:0] d3x, d3y;
        logic signed [35:0] vx, vy;
        d3x = {r9_qhx, 18'b0} + 35'(r9_qlx);
        d3y = {r9_qhy, 18'b0} + 35'(r9_qly);
        case (r9_ctl.cnt)
            3'd2: begin
                vx = 36'(r9_qx >>> 1);
                vy = 36'(r9_qy >>> 1);
            end
            3'd3: begin
                vx = $signed({1'b0, d3x}) - 36'sh1_0000_0000;
                vy = $signed({1'b0, d3y}) - 36'sh1_0000_0000;
            end
            3'd4: begin
                vx = 36'(r9_qx >>> 2);
                vy = 36'(r9_qy >>> 2);
            end
            default: begin
                vx = 36'(r9_qx);
                vy = 36'(r9_qy);
            end
        endcase
        n10_out.has_contact = r9_ctl.contact;
        n10_out.improved    = r9_imp;
        n10_out.contact_x   = r9_ctl.contact ? sat32(vx) : '0;
        n10_out.contact_y   = r9_ctl.contact ? sat32(vy) : '0;
        n10_out.pen_out     = r9_pen;
        n10_out.normal_x    = r9_nx;
        n10_out.normal_y    = r9_ny;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_ctl.vld <= 1'b0;
            r8_ctl.vld <= 1'b0;
            r9_ctl.vld <= 1'b0;
            r10_vld    <= 1'b0;
        end else if (i_en) begin
            r7_ctl.vld <= i_ctl.vld;
            r8_ctl.vld <= r7_ctl.vld;
            r9_ctl.vld <= r8_ctl.vld;
            r10_vld    <= r9_ctl.vld;

            r7_ctl.contact <= i_ctl.contact;
            r7_ctl.cnt     <= i_ctl.cnt;
            r7_qx  <= n7_qx;
            r7_qy  <= n7_qy;
            r7_pen <= n7_pen;
            r7_nx  <= n7_nx;
            r7_ny  <= n7_ny;
            r7_imp <= n7_imp;

            r8_ctl.contact <= r7_ctl.contact;
            r8_ctl.cnt     <= r7_ctl.cnt;
            r8_qx  <= r7_qx;
            r8_qy  <= r7_qy;
            r8_pen <= r7_pen;
            r8_nx  <= r7_nx;
            r8_ny  <= r7_ny;
            r8_imp <= r7_imp;
            r8_qhx <= prod_hx[34:19];
            r8_qhy <= prod_hy[34:19];
            r8_xhx <= bx[34:18];
            r8_xhy <= by[34:18];
            r8_xlx <= bx[17:0];
            r8_xly <= by[17:0];

            r9_ctl.contact <= r8_ctl.contact;
            r9_ctl.cnt     <= r8_ctl.cnt;
            r9_qx  <= r8_qx;
            r9_qy  <= r8_qy;
            r9_pen <= r8_pen;
            r9_nx  <= r8_nx;
            r9_ny  <= r8_ny;
            r9_imp <= r8_imp;
            r9_qhx <= r8_qhx;
            r9_qhy <= r8_qhy;
            r9_qlx <= prod_lx[39:21];
            r9_qly <= prod_ly[39:21];

            r10_out <= n10_out;
        end
    end

    assign o_vld = r10_vld;
    assign o_out = r10_out;

endmodule

// ===== sv/obbcp_checker.sv =====
module obbcp_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_stall,
    input obbcp_pkg::t_in  i_data,
    input logic            o_valid,
    input logic            i_stall,
    input obbcp_pkg::t_out o_data
);
    import obbcp_pkg::*;

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge i_clk)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting result");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_no_contact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.has_contact |->
            !o_data.improved && o_data.contact_x == 0 && o_data.contact_y == 0)
        else $error("no-contact result carries data");

    a_normal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.improved |-> o_data.normal_x == 0 && o_data.normal_y == 0)
        else $error("normal set without improvement");

endmodule

bind oriented_box_corner_penetration obbcp_checker u_obbcp_checker (.*);
